@@ design/chacha_pkg.sv @@
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared types, constants and helpers of the ChaCha20 stream cipher block.
// ----------------------------------------------------------------------------
package chacha_pkg;

	// "expand 32-byte k"
	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646E;
	localparam logic [31:0] SIGMA2 = 32'h79622D32;
	localparam logic [31:0] SIGMA3 = 32'h6B206574;

	// Quarter-round rotate amounts, in order of use
	localparam int unsigned ROT_A = 16;
	localparam int unsigned ROT_B = 12;
	localparam int unsigned ROT_C = 8;
	localparam int unsigned ROT_D = 7;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_PART3  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 3'd5;

	// Four state words handled by one quarter-round lane
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} qr_words_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
		return (v << s) | (v >> (32 - s));
	endfunction

endpackage

@@ design/chacha_qr_step.sv @@
// ----------------------------------------------------------------------------
// chacha_qr_step
// Half of a ChaCha quarter round: two add-xor-rotate steps on one lane.
// ----------------------------------------------------------------------------
module chacha_qr_step import chacha_pkg::*; (
	input  logic      second_half,
	input  qr_words_t din,
	output qr_words_t dout
);

	logic [31:0] a_sum;
	logic [31:0] d_mix;
	logic [31:0] d_rot;
	logic [31:0] c_sum;
	logic [31:0] b_mix;
	logic [31:0] b_rot;

	always_comb begin
		a_sum = din.a + din.b;
		d_mix = din.d ^ a_sum;
		d_rot = second_half ? rotl32(d_mix, ROT_C) : rotl32(d_mix, ROT_A);
		c_sum = din.c + d_rot;
		b_mix = din.b ^ c_sum;
		b_rot = second_half ? rotl32(b_mix, ROT_D) : rotl32(b_mix, ROT_B);
	end

	assign dout = '{a: a_sum, b: b_rot, c: c_sum, d: d_rot};

endmodule

@@ design/chacha20_stream_cipher.sv @@
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 keystream XOR, eight message bytes per word.
// ----------------------------------------------------------------------------
// Each input word is XORed with the next eight bytes of the ChaCha20 keystream
// (little-endian, first byte in the low bits); bytes above valid_bytes come out
// zero and valid_bytes_out copies the raw count. The key and nonce come from
// the configuration registers; the 32-bit block counter restarts at 0 on a
// word with first_word set. A new 64-byte block is generated on every eighth
// word, and on any word with first_word set, by one shared bank of four
// quarter-round lanes, which does half a round per cycle: a word that starts
// a block passes through ST_ROUND and ST_FEED before ST_EMIT, while the
// other words go from ST_IDLE straight to ST_EMIT. The block takes one word
// at a time; a finished result waits in the output register while the next
// word is accepted.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher import chacha_pkg::*; #(
	parameter int unsigned DOUBLE_ROUNDS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// input words
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [63:0]           data_in,
	input  logic [3:0]            valid_bytes,
	input  logic                  first_word,
	// result words
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [63:0]           data_out,
	output logic [3:0]            valid_bytes_out
);

	// Each double round is four half-round steps (column then diagonal)
	localparam int unsigned STEPS  = 4 * DOUBLE_ROUNDS;
	localparam int unsigned STEP_W = $clog2(STEPS);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_FEED  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;

	// configuration
	logic [63:0] key_q [4];
	logic [63:0] nonce_low_q;
	logic [31:0] nonce_high_q;

	// sequencing
	logic [31:0]       ctr_q;
	logic [2:0]        pos_q;
	logic [STEP_W-1:0] step_q;

	// held word
	logic [63:0] data_q;
	logic [3:0]  count_q;

	// working state; after the feed-forward it holds the keystream block
	logic [31:0] x_q [16];
	logic [31:0] init_w [16];
	logic [31:0] ctr_sel;

	// output register
	logic        out_valid_q;
	logic [63:0] data_out_q;
	logic [3:0]  vb_out_q;

	logic        in_fire;
	logic        need_block;
	logic        out_free;
	logic        diag;
	logic [3:0]  ia [4];
	logic [3:0]  ib [4];
	logic [3:0]  ic [4];
	logic [3:0]  id [4];
	qr_words_t   qin [4];
	qr_words_t   qout [4];
	logic [63:0] ks;
	logic [63:0] mask;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign need_block = first_word || (pos_q == 3'd0);
	assign out_free   = !out_valid_q || out_ready;
	assign diag       = step_q[1];

	// Block counter for the initial state: a new message starts at block 0
	assign ctr_sel = (state_q == ST_IDLE && first_word) ? 32'd0 : ctr_q;

	always_comb begin
		init_w[0] = SIGMA0;
		init_w[1] = SIGMA1;
		init_w[2] = SIGMA2;
		init_w[3] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init_w[4 + 2*i] = key_q[i][31:0];
			init_w[5 + 2*i] = key_q[i][63:32];
		end
		init_w[12] = ctr_sel;
		init_w[13] = nonce_low_q[31:0];
		init_w[14] = nonce_low_q[63:32];
		init_w[15] = nonce_high_q;
	end

	// Lane j works on column j, or on the diagonal that starts at word j
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			ia[j] = {2'd0, 2'(j)};
			ib[j] = {2'd1, 2'(j) + (diag ? 2'd1 : 2'd0)};
			ic[j] = {2'd2, 2'(j) + (diag ? 2'd2 : 2'd0)};
			id[j] = {2'd3, 2'(j) + (diag ? 2'd3 : 2'd0)};
			qin[j] = '{a: x_q[ia[j]], b: x_q[ib[j]], c: x_q[ic[j]], d: x_q[id[j]]};
		end
	end

	for (genvar j = 0; j < 4; j++) begin : g_lane
		chacha_qr_step u_qr (
			.second_half(step_q[0]),
			.din        (qin[j]),
			.dout       (qout[j])
		);
	end

	// Keystream word for the current position, and the byte mask
	assign ks = {x_q[{pos_q, 1'b1}], x_q[{pos_q, 1'b0}]};

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			mask[8*i +: 8] = (count_q > 4'(i)) ? 8'hFF : 8'h00;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
			nonce_low_q  <= '0;
			nonce_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_KEY_PART0:  key_q[0]     <= cfg_wdata;
				REG_KEY_PART1:  key_q[1]     <= cfg_wdata;
				REG_KEY_PART2:  key_q[2]     <= cfg_wdata;
				REG_KEY_PART3:  key_q[3]     <= cfg_wdata;
				REG_NONCE_LOW:  nonce_low_q  <= cfg_wdata;
				REG_NONCE_HIGH: nonce_high_q <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ctr_q       <= '0;
			pos_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raise on a fresh result, drop once the receiver takes it
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (first_word) begin
							ctr_q <= '0;
							pos_q <= '0;
						end
						step_q  <= '0;
						state_q <= need_block ? ST_ROUND : ST_EMIT;
					end
				end
				ST_ROUND: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(STEPS - 1)) begin
						state_q <= ST_FEED;
					end
				end
				ST_FEED: begin
					// block is complete: advance the counter
					ctr_q   <= ctr_q + 32'd1;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (out_free) begin
						pos_q   <= pos_q + 3'd1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_q  <= data_in;
			count_q <= valid_bytes;
			if (need_block) begin
				for (int i = 0; i < 16; i++) begin
					x_q[i] <= init_w[i];
				end
			end
		end
		if (state_q == ST_ROUND) begin
			for (int j = 0; j < 4; j++) begin
				x_q[ia[j]] <= qout[j].a;
				x_q[ib[j]] <= qout[j].b;
				x_q[ic[j]] <= qout[j].c;
				x_q[id[j]] <= qout[j].d;
			end
		end
		if (state_q == ST_FEED) begin
			for (int i = 0; i < 16; i++) begin
				x_q[i] <= x_q[i] + init_w[i];
			end
		end
		if (state_q == ST_EMIT && out_free) begin
			data_out_q <= (data_q ^ ks) & mask;
			vb_out_q   <= count_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign data_out        = data_out_q;
	assign valid_bytes_out = vb_out_q;

endmodule
